[design/sssf_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sssf_pkg
// Shared types, codes and constants of the steer slew filter.
// ----------------------------------------------------------------------------
package sssf_pkg;

  localparam int unsigned CfgIdxW = 3;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_CURVE_SENS = 3'd0,
    CFG_MAX_SLEW   = 3'd1,
    CFG_MIN_SLEW   = 3'd2,
    CFG_MIN_ERR    = 3'd3,
    CFG_MAX_ERR    = 3'd4,
    CFG_SPEED_BP   = 3'd5,
    CFG_RATE_FAC   = 3'd6
  } cfg_idx_e;

  localparam logic [16:0] CurveSensRst = 17'd32768;
  localparam logic [15:0] MaxSlewRst   = 16'd512;
  localparam logic [15:0] MinSlewRst   = 16'd26;
  localparam logic [15:0] MinErrRst    = 16'd256;
  localparam logic [15:0] MaxErrRst    = 16'd512;
  localparam logic [63:0] SpeedBpRst   = 64'd1125912791875904;
  localparam logic [63:0] RateFacRst   = 64'd144117387132666368;

  localparam logic [40:0] CubeCap   = 41'h100_0000_0000;
  localparam logic [16:0] UnityQ16  = 17'h10000;
  localparam logic [15:0] UnityRate = 16'd256;
  localparam logic [9:0]  FiltScale = 10'd1000;
  localparam logic [31:0] SpdRound  = 32'd5;
  // floor(x / 10) for any 32-bit x is (x * SpdRecip) >> 35
  localparam logic [31:0] SpdRecip  = 32'hcccc_cccd;

  typedef enum logic [4:0] {
    OP_NONE, OP_LOAD, OP_FMUL, OP_FDIV, OP_FEND, OP_SQ, OP_CUBE, OP_CURVE1,
    OP_CURVE2, OP_VX, OP_VY, OP_VZ, OP_SQRT, OP_SDIV, OP_SPD, OP_SEG,
    OP_RATE, OP_MD1, OP_MD2, OP_HI, OP_LO, OP_WDIV, OP_WEND, OP_LIM1,
    OP_LIM2, OP_FIN
  } op_e;

  typedef enum logic [4:0] {
    ST_IDLE, ST_FMUL, ST_FDIV, ST_FWAIT, ST_FEND, ST_SQ, ST_CUBE, ST_CURVE1,
    ST_CURVE2, ST_VX, ST_VY, ST_VZ, ST_SQRT, ST_SWAIT, ST_SDIV,
    ST_SPD, ST_SEG, ST_RWAIT, ST_RATE, ST_MD1, ST_MD2, ST_HI, ST_LO,
    ST_WDIV, ST_WWAIT, ST_WEND, ST_LIM1, ST_LIM2, ST_FIN
  } state_e;

  typedef struct packed {
    op_e op;
  } cmd_t;

  typedef struct packed {
    logic div_busy;
    logic sqrt_busy;
    logic out_free;
  } status_t;

  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    logic signed [31:0] r;
    if (v > 64'sd2147483647) r = 32'sh7fff_ffff;
    else if (v < -64'sd2147483648) r = 32'sh8000_0000;
    else r = v[31:0];
    return r;
  endfunction

endpackage
`default_nettype wire

[design/sssf_div.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sssf_div
// Shared restoring divider, 64-bit dividend by 32-bit divisor, one bit a cycle.
// ----------------------------------------------------------------------------
module sssf_div (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start_i,
  input  wire logic [63:0] num_i,
  input  wire logic [31:0] den_i,
  output logic             busy_o,
  output logic [63:0]      quo_o
);
  logic [63:0] dq_q;
  logic [31:0] rem_q, den_q;
  logic [6:0]  cnt_q;
  logic [32:0] trial;

  assign trial = {rem_q, dq_q[63]};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (start_i) begin
      cnt_q <= 7'd64;
    end else if (cnt_q != '0) begin
      cnt_q <= cnt_q - 7'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      dq_q  <= num_i;
      rem_q <= '0;
      den_q <= den_i;
    end else if (cnt_q != '0) begin
      if (trial >= {1'b0, den_q}) begin
        rem_q <= 32'(trial - {1'b0, den_q});
        dq_q  <= {dq_q[62:0], 1'b1};
      end else begin
        rem_q <= trial[31:0];
        dq_q  <= {dq_q[62:0], 1'b0};
      end
    end
  end

  assign busy_o = (cnt_q != '0);
  assign quo_o  = dq_q;
endmodule
`default_nettype wire

[design/sssf_sqrt.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sssf_sqrt
// Floor square root of a 48-bit value, two radicand bits a cycle.
// ----------------------------------------------------------------------------
module sssf_sqrt (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start_i,
  input  wire logic [47:0] val_i,
  output logic             busy_o,
  output logic [23:0]      root_o
);
  logic [47:0] v_q, r_q, bit_q;
  logic        busy_q;
  logic [47:0] rb;

  assign rb = r_q + bit_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
    end else if (start_i) begin
      busy_q <= 1'b1;
    end else if (busy_q && bit_q[1:0] != 2'b00) begin
      busy_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      v_q   <= val_i;
      r_q   <= '0;
      bit_q <= 48'h4000_0000_0000;
    end else if (busy_q) begin
      if (v_q >= rb) begin
        v_q <= v_q - rb;
        r_q <= (r_q >> 1) + bit_q;
      end else begin
        r_q <= r_q >> 1;
      end
      bit_q <= bit_q >> 2;
    end
  end

  assign busy_o = busy_q;
  assign root_o = r_q[23:0];
endmodule
`default_nettype wire

[design/sssf_datapath.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sssf_datapath
// Registers, arithmetic steps, shared divider and square root of the filter.
// ----------------------------------------------------------------------------
module sssf_datapath (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire sssf_pkg::cmd_t       cmd_i,
  output sssf_pkg::status_t         status_o,
  input  wire logic                 cfg_we_i,
  input  wire logic [2:0]           cfg_index_i,
  input  wire logic [63:0]          cfg_data_i,
  input  wire logic signed [15:0]   target_steer_i,
  input  wire logic [15:0]          time_step_i,
  input  wire logic [15:0]          filter_time_ms_i,
  input  wire logic signed [23:0]   velocity_x_i,
  input  wire logic signed [23:0]   velocity_y_i,
  input  wire logic signed [23:0]   velocity_z_i,
  input  wire logic                 out_stall_i,
  output logic                      out_valid_o,
  output logic signed [31:0]        steer_out_o,
  output logic signed [31:0]        filtered_stick_o,
  output logic signed [31:0]        previous_filtered_o
);
  import sssf_pkg::*;

  // configuration
  logic [16:0] cs_q;
  logic [15:0] max_slew_q, min_slew_q, min_err_q, max_err_q;
  logic [63:0] bp_q, rf_q;

  // state
  logic signed [31:0] lp_q, sp_q;
  logic               out_valid_q;

  // working registers
  logic [15:0]        d_q, ms_q;
  logic signed [23:0] vx_q, vy_q, vz_q;
  logic [32:0]        magd_q;
  logic               dpos_q;
  logic [31:0]        m_q;
  logic [63:0]        prod_q;
  logic signed [31:0] l1_q;
  logic [46:0]        sq_q;
  logic [40:0]        cube_q;
  logic signed [43:0] e_q;
  logic [42:0]        ae_q;
  logic [47:0]        sum_q;
  logic [31:0]        spd_x_q;
  logic [25:0]        spd_q;
  logic               top_q;
  logic [15:0]        ra_q, rb_q;
  logic [24:0]        rate16_q;
  logic [31:0]        md_q, nd_q;
  logic [23:0]        a_q, b_q, mxf_q, lim_q;
  logic [33:0]        hi_q, lo_q;
  logic               wz_q;
  logic [16:0]        w_q;

  // shared units
  logic        div_start, div_busy, sqrt_busy;
  logic [63:0] div_num, div_quo;
  logic [31:0] div_den;
  logic [23:0] root;

  sssf_div u_div (
    .clk_i, .rst_ni, .start_i(div_start), .num_i(div_num), .den_i(div_den),
    .busy_o(div_busy), .quo_o(div_quo)
  );

  sssf_sqrt u_sqrt (
    .clk_i, .rst_ni, .start_i(cmd_i.op == OP_SQRT), .val_i(sum_q),
    .busy_o(sqrt_busy), .root_o(root)
  );

  // combinational helpers
  logic signed [16:0] tgt;
  logic signed [33:0] diff;
  logic [16:0]        sens;
  logic [19:0]        bq0, bq1, bq2, bq3, base, nxt;
  logic [15:0]        sra, srb;
  logic               stop;
  logic [25:0]        seg_off;
  logic [19:0]        seg_w;

  assign tgt  = {target_steer_i, 1'b0};
  assign diff = 34'(tgt) - 34'(lp_q);
  assign sens = (cs_q > UnityQ16) ? UnityQ16 : cs_q;
  assign bq0  = {bp_q[15:0], 4'b0};
  assign bq1  = {bp_q[31:16], 4'b0};
  assign bq2  = {bp_q[47:32], 4'b0};
  assign bq3  = {bp_q[63:48], 4'b0};

  // highest breakpoint tested first
  always_comb begin
    stop = 1'b0;
    if (spd_q >= 26'(bq3)) begin
      stop = 1'b1; base = bq3; nxt = bq3; sra = rf_q[63:48]; srb = rf_q[63:48];
    end else if (spd_q >= 26'(bq2)) begin
      base = bq2; nxt = bq3; sra = rf_q[47:32]; srb = rf_q[63:48];
    end else if (spd_q >= 26'(bq1)) begin
      base = bq1; nxt = bq2; sra = rf_q[31:16]; srb = rf_q[47:32];
    end else if (spd_q >= 26'(bq0)) begin
      base = bq0; nxt = bq1; sra = rf_q[15:0]; srb = rf_q[31:16];
    end else begin
      base = '0; nxt = bq0; sra = UnityRate; srb = rf_q[15:0];
    end
  end
  assign seg_off = spd_q - 26'(base);
  assign seg_w   = nxt - base;

  logic [58:0] fnum;
  assign fnum = prod_q[48:0] * FiltScale;

  always_comb begin
    div_start = 1'b0;
    div_num   = '0;
    div_den   = '0;
    case (cmd_i.op)
      OP_FDIV: begin
        div_start = 1'b1;
        div_num   = 64'(fnum) + 64'({ms_q, 15'b0});
        div_den   = {ms_q, 16'b0};
      end
      OP_SEG: begin
        div_start = 1'b1;
        div_num   = {22'b0, seg_off, 16'b0};
        div_den   = 32'(seg_w);
      end
      OP_WDIV: begin
        div_start = 1'b1;
        div_num   = {5'b0, 43'(ae_q - 43'(a_q)), 16'b0};
        div_den   = 32'(b_q - a_q);
      end
      default: ;
    endcase
  end

  // step arithmetic
  logic signed [63:0] fsum;
  logic [63:0]        sq_full, cube_full;
  logic [47:0]        cube_t;
  logic [48:0]        msens;
  logic [63:0]        cv_t;
  logic [41:0]        cu;
  logic signed [63:0] c64, e64, ae64;
  logic signed [47:0] vx2, vy2, vz2;
  logic [63:0]        spd_p;
  logic [16:0]        f;
  logic [32:0]        r24, lerp_a, lerp_b;
  logic [33:0]        r24r;
  logic [56:0]        hip, lop;
  logic [50:0]        hiw;
  logic [63:0]        lim_t;
  logic [35:0]        lim_s;
  logic signed [43:0] lim_e, ec;
  logic signed [31:0] s1;

  assign fsum = dpos_q ? 64'(lp_q) + $signed({16'b0, div_quo[47:0]})
                       : 64'(lp_q) - $signed({16'b0, div_quo[47:0]});
  assign sq_full   = m_q * m_q;
  assign cube_full = sq_q[31:0] * m_q;
  assign cube_t    = cube_full[63:16];
  assign msens     = m_q * sens;
  assign cv_t      = prod_q + 64'(msens) + 64'd32768;
  assign cu        = cv_t[57:16];
  assign c64       = lp_q[31] ? -$signed(64'(cu)) : $signed(64'(cu));
  assign e64       = c64 - 64'(sp_q);
  assign ae64      = e64[63] ? -e64 : e64;
  assign vx2       = vx_q * vx_q;
  assign vy2       = vy_q * vy_q;
  assign vz2       = vz_q * vz_q;
  assign spd_p     = spd_x_q * SpdRecip;
  assign f         = div_quo[16:0];
  assign lerp_a    = ra_q * (UnityQ16 - f);
  assign lerp_b    = rb_q * f;
  assign r24       = top_q ? {1'b0, rf_q[63:48], 16'b0} : lerp_a + lerp_b;
  assign r24r      = 34'(r24) + 34'd128;
  assign hip       = md_q * rate16_q;
  assign lop       = nd_q * rate16_q;
  assign hiw       = hi_q * w_q;
  assign lim_t     = prod_q + 64'(hiw) + 64'd32768;
  assign lim_s     = lim_t[51:16];
  assign lim_e     = $signed({20'b0, lim_q});
  assign ec        = (e_q > lim_e) ? lim_e : ((e_q < -lim_e) ? -lim_e : e_q);
  assign s1        = sat32(64'(sp_q) + 64'(ec));

  always_ff @(posedge clk_i) begin
    case (cmd_i.op)
      OP_LOAD: begin
        d_q    <= time_step_i;
        ms_q   <= (filter_time_ms_i == '0) ? 16'd1 : filter_time_ms_i;
        vx_q   <= velocity_x_i;
        vy_q   <= velocity_y_i;
        vz_q   <= velocity_z_i;
        magd_q <= diff[33] ? 33'(-diff) : diff[32:0];
        dpos_q <= !diff[33];
        m_q    <= lp_q[31] ? 32'(-lp_q) : 32'(lp_q);
      end
      OP_FMUL:   prod_q <= 64'(magd_q * d_q);
      OP_FEND:   l1_q   <= sat32(fsum);
      OP_SQ:     sq_q   <= sq_full[62:16];
      OP_CUBE: begin
        if (sq_q[46:32] != '0) cube_q <= CubeCap;
        else if (cube_t > 48'(CubeCap)) cube_q <= CubeCap;
        else cube_q <= cube_t[40:0];
      end
      OP_CURVE1: prod_q <= 64'(cube_q * (UnityQ16 - sens));
      OP_CURVE2: begin
        e_q  <= e64[43:0];
        ae_q <= ae64[42:0];
      end
      OP_VX:     sum_q <= 48'(vx2);
      OP_VY:     sum_q <= sum_q + 48'(vy2);
      OP_VZ:     sum_q <= sum_q + 48'(vz2);
      // root * 3.6 with rounding, divided by ten through the reciprocal
      OP_SDIV:   spd_x_q <= 32'({root, 5'b0}) + 32'({root, 2'b0}) + SpdRound;
      OP_SPD:    spd_q <= spd_p[60:35];
      OP_SEG: begin
        top_q <= stop;
        ra_q  <= sra;
        rb_q  <= srb;
      end
      OP_RATE:   rate16_q <= r24r[32:8];
      OP_MD1: begin
        md_q <= max_slew_q * d_q;
        nd_q <= min_slew_q * d_q;
      end
      OP_MD2: begin
        a_q   <= 24'((33'(min_err_q * d_q) + 33'd128) >> 8);
        b_q   <= 24'((33'(max_err_q * d_q) + 33'd128) >> 8);
        mxf_q <= 24'((33'(md_q) + 33'd128) >> 8);
      end
      OP_HI:     hi_q <= 34'((58'(hip) + 58'h80_0000) >> 24);
      OP_LO:     lo_q <= 34'((58'(lop) + 58'h80_0000) >> 24);
      OP_WDIV:   wz_q <= (b_q <= a_q) || (ae_q <= 43'(a_q));
      OP_WEND: begin
        if (wz_q) w_q <= '0;
        else if (div_quo > 64'(UnityQ16)) w_q <= UnityQ16;
        else w_q <= div_quo[16:0];
      end
      OP_LIM1:   prod_q <= 64'(lo_q * (UnityQ16 - w_q));
      OP_LIM2:   lim_q  <= (lim_s >= 36'(mxf_q)) ? mxf_q : lim_s[23:0];
      OP_FIN: begin
        steer_out_o         <= s1;
        filtered_stick_o    <= l1_q;
        previous_filtered_o <= lp_q;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lp_q        <= '0;
      sp_q        <= '0;
      out_valid_q <= 1'b0;
    end else if (cmd_i.op == OP_FIN) begin
      lp_q        <= l1_q;
      sp_q        <= s1;
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cs_q       <= CurveSensRst;
      max_slew_q <= MaxSlewRst;
      min_slew_q <= MinSlewRst;
      min_err_q  <= MinErrRst;
      max_err_q  <= MaxErrRst;
      bp_q       <= SpeedBpRst;
      rf_q       <= RateFacRst;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_index_i))
        CFG_CURVE_SENS: cs_q       <= cfg_data_i[16:0];
        CFG_MAX_SLEW:   max_slew_q <= cfg_data_i[15:0];
        CFG_MIN_SLEW:   min_slew_q <= cfg_data_i[15:0];
        CFG_MIN_ERR:    min_err_q  <= cfg_data_i[15:0];
        CFG_MAX_ERR:    max_err_q  <= cfg_data_i[15:0];
        CFG_SPEED_BP:   bp_q       <= cfg_data_i;
        CFG_RATE_FAC:   rf_q       <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign status_o.div_busy  = div_busy;
  assign status_o.sqrt_busy = sqrt_busy;
  assign status_o.out_free  = !out_valid_q || !out_stall_i;
  assign out_valid_o        = out_valid_q;

  a_div_idle_on_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_start |-> !div_busy)
    else $error("divider started while busy");

  a_fin_sets_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.op == OP_FIN) |=> out_valid_q)
    else $error("result not presented after finish");

  a_fin_needs_slot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.op == OP_FIN) |-> (!out_valid_q || !out_stall_i))
    else $error("result register overwritten");

  a_state_update: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.op == OP_FIN) |=> (lp_q == $past(l1_q)))
    else $error("filter state not updated");
endmodule
`default_nettype wire

[design/sssf_ctrl.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sssf_ctrl
// Step sequencer: walks one item through the datapath operations.
// ----------------------------------------------------------------------------
module sssf_ctrl (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_stall_o,
  input  wire sssf_pkg::status_t status_i,
  output sssf_pkg::cmd_t         cmd_o
);
  import sssf_pkg::*;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:   if (in_valid_i) state_d = ST_FMUL;
      ST_FMUL:   state_d = ST_FDIV;
      ST_FDIV:   state_d = ST_FWAIT;
      ST_FWAIT:  if (!status_i.div_busy) state_d = ST_FEND;
      ST_FEND:   state_d = ST_SQ;
      ST_SQ:     state_d = ST_CUBE;
      ST_CUBE:   state_d = ST_CURVE1;
      ST_CURVE1: state_d = ST_CURVE2;
      ST_CURVE2: state_d = ST_VX;
      ST_VX:     state_d = ST_VY;
      ST_VY:     state_d = ST_VZ;
      ST_VZ:     state_d = ST_SQRT;
      ST_SQRT:   state_d = ST_SWAIT;
      ST_SWAIT:  if (!status_i.sqrt_busy) state_d = ST_SDIV;
      ST_SDIV:   state_d = ST_SPD;
      ST_SPD:    state_d = ST_SEG;
      ST_SEG:    state_d = ST_RWAIT;
      ST_RWAIT:  if (!status_i.div_busy) state_d = ST_RATE;
      ST_RATE:   state_d = ST_MD1;
      ST_MD1:    state_d = ST_MD2;
      ST_MD2:    state_d = ST_HI;
      ST_HI:     state_d = ST_LO;
      ST_LO:     state_d = ST_WDIV;
      ST_WDIV:   state_d = ST_WWAIT;
      ST_WWAIT:  if (!status_i.div_busy) state_d = ST_WEND;
      ST_WEND:   state_d = ST_LIM1;
      ST_LIM1:   state_d = ST_LIM2;
      ST_LIM2:   state_d = ST_FIN;
      ST_FIN:    if (status_i.out_free) state_d = ST_IDLE;
      default:   state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o.op   = OP_NONE;
    in_stall_o = 1'b1;
    unique case (state_q)
      ST_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) cmd_o.op = OP_LOAD;
      end
      ST_FMUL:   cmd_o.op = OP_FMUL;
      ST_FDIV:   cmd_o.op = OP_FDIV;
      ST_FEND:   cmd_o.op = OP_FEND;
      ST_SQ:     cmd_o.op = OP_SQ;
      ST_CUBE:   cmd_o.op = OP_CUBE;
      ST_CURVE1: cmd_o.op = OP_CURVE1;
      ST_CURVE2: cmd_o.op = OP_CURVE2;
      ST_VX:     cmd_o.op = OP_VX;
      ST_VY:     cmd_o.op = OP_VY;
      ST_VZ:     cmd_o.op = OP_VZ;
      ST_SQRT:   cmd_o.op = OP_SQRT;
      ST_SDIV:   cmd_o.op = OP_SDIV;
      ST_SPD:    cmd_o.op = OP_SPD;
      ST_SEG:    cmd_o.op = OP_SEG;
      ST_RATE:   cmd_o.op = OP_RATE;
      ST_MD1:    cmd_o.op = OP_MD1;
      ST_MD2:    cmd_o.op = OP_MD2;
      ST_HI:     cmd_o.op = OP_HI;
      ST_LO:     cmd_o.op = OP_LO;
      ST_WDIV:   cmd_o.op = OP_WDIV;
      ST_WEND:   cmd_o.op = OP_WEND;
      ST_LIM1:   cmd_o.op = OP_LIM1;
      ST_LIM2:   cmd_o.op = OP_LIM2;
      ST_FIN:    if (status_i.out_free) cmd_o.op = OP_FIN;
      default:   cmd_o.op = OP_NONE;
    endcase
  end
endmodule
`default_nettype wire

[design/speed_scheduled_steer_slew_filter.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// speed_scheduled_steer_slew_filter
// Stick low-pass, response curve and speed-scheduled slew limiting of steer.
//
//   channel  direction  handshake                 beat
//   in       input      in_valid_i / in_stall_o   target, time step, ms, velocity
//   out      output     out_valid_o / out_stall_i steer, filtered, previous
//   cfg      input      cfg_valid_i / cfg_ready_o register index and data
//
// one item makes three passes through the shared divider, one through the square
// root and 25 single steps; the result is valid once the final step is taken and
// the next item can go in after it
// items are taken one at a time; the next is accepted while a result waits
// a result held by out_stall_i stalls only the final step of the next item
// reset clears filter state and loads register defaults; cfg_ready_o stays high
// ----------------------------------------------------------------------------
module speed_scheduled_steer_slew_filter (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_stall_o,
  input  wire logic signed [15:0] target_steer_i,
  input  wire logic [15:0]        time_step_i,
  input  wire logic [15:0]        filter_time_ms_i,
  input  wire logic signed [23:0] velocity_x_i,
  input  wire logic signed [23:0] velocity_y_i,
  input  wire logic signed [23:0] velocity_z_i,
  output logic                    out_valid_o,
  input  wire logic               out_stall_i,
  output logic signed [31:0]      steer_out_o,
  output logic signed [31:0]      filtered_stick_o,
  output logic signed [31:0]      previous_filtered_o,
  input  wire logic               cfg_valid_i,
  output logic                    cfg_ready_o,
  input  wire logic [2:0]         cfg_index_i,
  input  wire logic [63:0]        cfg_data_i
);
  import sssf_pkg::*;

  cmd_t    cmd;
  status_t status;

  assign cfg_ready_o = 1'b1;

  sssf_ctrl u_ctrl (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .status_i(status), .cmd_o(cmd)
  );

  sssf_datapath u_dp (
    .clk_i, .rst_ni, .cmd_i(cmd), .status_o(status),
    .cfg_we_i(cfg_valid_i && cfg_ready_o), .cfg_index_i, .cfg_data_i,
    .target_steer_i, .time_step_i, .filter_time_ms_i,
    .velocity_x_i, .velocity_y_i, .velocity_z_i,
    .out_stall_i, .out_valid_o, .steer_out_o, .filtered_stick_o,
    .previous_filtered_o
  );
endmodule
`default_nettype wire
